>>> hdl/hltd_pkg.sv
// shared types and constants for the header, length and tail deframer
package hltd_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 16;
  localparam int POS_W  = 17;
  localparam int HDR_W  = 32;
  localparam int IDX_W  = 2;

  localparam logic [IDX_W-1:0] CFG_HEADER = 2'd0;
  localparam logic [IDX_W-1:0] CFG_TAIL   = 2'd1;
  localparam logic [IDX_W-1:0] CFG_LIMIT  = 2'd2;

  localparam logic [LEN_W-1:0] LIMIT_RESET = 16'd1024;

  localparam logic [1:0] EV_PAYLOAD = 2'd0;
  localparam logic [1:0] EV_ACCEPT  = 2'd1;
  localparam logic [1:0] EV_DROP    = 2'd2;

  localparam logic [POS_W-1:0] HDR_BYTES   = 17'd4;
  localparam logic [POS_W-1:0] POS_LEN_LO  = 17'd4;
  localparam logic [POS_W-1:0] TAIL_OFFSET = 17'd5;

  typedef struct packed {
    logic [HDR_W-1:0]  header_pattern;
    logic [BYTE_W-1:0] tail_value;
    logic [LEN_W-1:0]  payload_limit;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
    logic [1:0]        ev;
  } res_t;

endpackage

>>> hdl/hltd_parser.sv
// frame position tracking and per-byte result decode
module hltd_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       take,
  input  logic [hltd_pkg::BYTE_W-1:0] rx_byte,
  input  hltd_pkg::cfg_t             cfg,
  output hltd_pkg::res_t             res,
  output logic [hltd_pkg::POS_W-1:0] pos
);

  logic [hltd_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [hltd_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic [hltd_pkg::BYTE_W-1:0] hdr_byte;
  logic [hltd_pkg::LEN_W-1:0]  len_full;
  logic [hltd_pkg::POS_W-1:0]  tail_pos;
  logic [hltd_pkg::POS_W-1:0]  limit_p1;

  assign hdr_byte = hltd_pkg::BYTE_W'(cfg.header_pattern >> {pos_r[1:0], 3'b000});
  assign len_full = {rx_byte, len_r[hltd_pkg::BYTE_W-1:0]};
  assign tail_pos = {1'b0, len_r} + hltd_pkg::TAIL_OFFSET;
  assign limit_p1 = {1'b0, cfg.payload_limit} + 17'd1;

  always_comb begin
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    res.valid = 1'b0;
    res.data  = '0;
    res.ev    = hltd_pkg::EV_PAYLOAD;
    priority if (pos_r < hltd_pkg::HDR_BYTES) begin
      pos_nxt = (rx_byte == hdr_byte) ? pos_r + 17'd1 : '0;
    end else if (pos_r == hltd_pkg::POS_LEN_LO) begin
      len_nxt = {8'd0, rx_byte};
      pos_nxt = pos_r + 17'd1;
    end else if (pos_r == hltd_pkg::TAIL_OFFSET) begin
      len_nxt = len_full;
      if (len_full == '0 || {1'b0, len_full} > limit_p1) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + 17'd1;
      end
    end else if (pos_r >= tail_pos) begin
      res.valid = 1'b1;
      res.ev    = (rx_byte == cfg.tail_value) ? hltd_pkg::EV_ACCEPT : hltd_pkg::EV_DROP;
      pos_nxt   = '0;
    end else begin
      res.valid = 1'b1;
      res.data  = rx_byte;
      pos_nxt   = pos_r + 17'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      len_r <= '0;
    end else if (take) begin
      pos_r <= pos_nxt;
      len_r <= len_nxt;
    end
  end

  assign pos = pos_r;

endmodule

>>> hdl/header_length_tail_deframer.sv
// deframer top level: config registers, parser and result register
// a result beat is registered and appears in the cycle after the byte that causes it
// throughput: one byte per cycle unless a held result beat is stalled, set by the single result register
// in_stall is high only while a held result beat is itself stalled
// reset returns to header hunting, length zero, registers to reset values
// header and length bytes, and silently dropped lengths, give no beat
module header_length_tail_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_event_res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  hltd_pkg::cfg_t cfg_r;
  hltd_pkg::res_t res;
  logic           take;
  logic [16:0]    pos;
  logic           out_valid_r;
  logic [7:0]     out_byte_r;
  logic [1:0]     out_ev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_pattern <= '0;
      cfg_r.tail_value     <= '0;
      cfg_r.payload_limit  <= hltd_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hltd_pkg::CFG_HEADER: cfg_r.header_pattern <= cfg_wdata;
        hltd_pkg::CFG_TAIL:   cfg_r.tail_value     <= cfg_wdata[7:0];
        hltd_pkg::CFG_LIMIT:  cfg_r.payload_limit  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign in_stall = out_valid_r & out_stall;
  assign take     = in_valid & ~in_stall;

  hltd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (in_rx_byte),
    .cfg     (cfg_r),
    .res     (res),
    .pos     (pos)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!in_stall) begin
      out_valid_r <= take & res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res.valid) begin
      out_byte_r <= res.data;
      out_ev_r   <= res.ev;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_event_res = out_ev_r;

  a_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res != hltd_pkg::EV_PAYLOAD |-> out_byte == 8'd0)
    else $error("tail beat carries nonzero byte");

  a_ev_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_event_res == hltd_pkg::EV_PAYLOAD ||
                  out_event_res == hltd_pkg::EV_ACCEPT ||
                  out_event_res == hltd_pkg::EV_DROP)
    else $error("bad event code");

  a_tail_rehunt: assert property (@(posedge clk) disable iff (!rst_n)
    take && res.valid && res.ev != hltd_pkg::EV_PAYLOAD |=> pos == 17'd0)
    else $error("no header hunt after tail");

  a_hdr_silent: assert property (@(posedge clk) disable iff (!rst_n)
    pos <= hltd_pkg::TAIL_OFFSET |-> !res.valid)
    else $error("beat during header or length");

endmodule
